// ===== hw/rtl/tpc_pkg.sv =====
// shared constants, types and register codes of the three-axis position controller
package tpc_pkg;

  localparam int NUM_LANES     = 3;
  localparam int HEADING_LANE  = 2;
  localparam int DEF_AXES      = 3;
  localparam int DEF_FRAC_BITS = 16;

  localparam int DATA_W  = 32;
  localparam int ERR_W   = 33;
  localparam int SUM_W   = 48;
  localparam int SUM_LO_W = SUM_W / 2;
  localparam int LIMIT_W = 31;
  localparam int IDX_W   = 3;

  localparam int HALF_TURN = 180;
  // half turn split as 4 * 45: the low two integer bits pass straight through
  localparam int RED_DIV   = HALF_TURN / 4;

  // stages: error, heading divide, heading remainder, accumulate, multiply, scale, output
  localparam int NUM_STAGES = 7;

  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEGRAL_GAIN  = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integral_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic [LIMIT_W-1:0]       integral_limit;
    logic [LIMIT_W-1:0]       output_limit;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic                  out_valid;
  } pipe_ctrl_t;

endpackage

// ===== hw/rtl/tpc_ctrl.sv =====
// stage valid bits and per-stage load enables of the lane pipeline
module tpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output tpc_pkg::pipe_ctrl_t ctrl_o
);

  logic [tpc_pkg::NUM_STAGES-1:0] valid_q, valid_d, adv, vin;

  always_comb begin
    adv[tpc_pkg::NUM_STAGES-1] = !valid_q[tpc_pkg::NUM_STAGES-1] || out_ready_i;
    for (int k = tpc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    vin = {valid_q[tpc_pkg::NUM_STAGES-2:0], in_valid_i};
    for (int k = 0; k < tpc_pkg::NUM_STAGES; k++) begin
      valid_d[k] = adv[k] ? vin[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o       = adv[0];
  assign ctrl_o.en        = adv & vin;
  assign ctrl_o.out_valid = valid_q[tpc_pkg::NUM_STAGES-1];

endmodule

// ===== hw/rtl/tpc_lane.sv =====
// one pid lane: error, heading remainder, saturating sum, gain products and scaling
module tpc_lane #(
  parameter int FRAC_BITS = tpc_pkg::DEF_FRAC_BITS,
  parameter bit HEADING   = 1'b0,
  localparam int P_W = tpc_pkg::ERR_W + tpc_pkg::DATA_W - FRAC_BITS,
  localparam int D_W = tpc_pkg::ERR_W + 1 + tpc_pkg::DATA_W - FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tpc_pkg::pipe_ctrl_t              ctrl_i,
  input  tpc_pkg::cfg_t                    cfg_i,
  input  logic signed [tpc_pkg::DATA_W-1:0] target_i,
  input  logic signed [tpc_pkg::DATA_W-1:0] measured_i,
  output logic signed [P_W-1:0]            pterm_o,
  output logic signed [D_W-1:0]            dterm_o,
  output logic signed [tpc_pkg::DATA_W-1:0] iterm_o
);

  localparam int EW   = tpc_pkg::ERR_W;
  localparam int SW   = tpc_pkg::SUM_W;
  localparam int LW   = tpc_pkg::SUM_LO_W;
  localparam int PP_W = EW + tpc_pkg::DATA_W;
  localparam int DP_W = EW + 1 + tpc_pkg::DATA_W;
  localparam int IL_W = LW + 1 + tpc_pkg::DATA_W;
  localparam int IH_W = SW - LW + tpc_pkg::DATA_W;
  localparam int IP_W = SW + tpc_pkg::DATA_W;
  localparam int IS_W = IP_W - FRAC_BITS;

  logic signed [EW-1:0]   err_a_q, err_c_q;
  logic signed [EW-1:0]   prev_q;
  logic signed [SW-1:0]   sum_q, sum_d;
  logic signed [SW:0]     sum_ext;
  logic signed [EW:0]     diff_q;
  logic signed [PP_W-1:0] pprod_q;
  logic signed [DP_W-1:0] dprod_q;
  logic signed [IL_W-1:0] ilo_q;
  logic signed [IH_W-1:0] ihi_q;
  logic signed [IP_W-1:0] ihi_ext, ilo_ext, iprod;
  logic signed [IS_W-1:0] ifull, ilim;
  logic signed [tpc_pkg::DATA_W-1:0] iclamp;

  // error
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      err_a_q <= EW'(target_i) - EW'(measured_i);
    end
  end

  if (HEADING) begin : g_heading
    localparam int LOW_W = FRAC_BITS + 2;
    localparam int W     = tpc_pkg::DATA_W - LOW_W;
    localparam int S     = W + 6;
    localparam int MW    = W + 1;
    localparam int QW    = W - 5;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << S) / tpc_pkg::RED_DIV);

    logic [EW-1:0]     mag;
    logic [W-1:0]      y;
    logic [W+MW-1:0]   prod;
    logic [QW-1:0]     quot_q;
    logic [W-1:0]      y_q;
    logic [LOW_W-1:0]  low_q;
    logic              neg_q;
    logic [W:0]        qm, rfull;
    logic [6:0]        r7;
    logic [5:0]        rr;
    logic signed [EW-1:0] rem;

    always_comb begin
      mag  = err_a_q[EW-1] ? 33'(-err_a_q) : 33'(err_a_q);
      y    = mag[tpc_pkg::DATA_W-1:LOW_W];
      prod = (W+MW)'(y) * (W+MW)'(RECIP);
    end

    // quotient estimate by reciprocal, low by at most one
    always_ff @(posedge clk_i) begin
      if (ctrl_i.en[1]) begin
        quot_q <= prod[S +: QW];
        y_q    <= y;
        low_q  <= mag[LOW_W-1:0];
        neg_q  <= err_a_q[EW-1];
      end
    end

    always_comb begin
      qm    = (W+1)'(quot_q) * (W+1)'(tpc_pkg::RED_DIV);
      rfull = {1'b0, y_q} - qm;
      r7    = rfull[6:0];
      rr    = (r7 >= 7'(tpc_pkg::RED_DIV)) ? 6'(r7 - 7'(tpc_pkg::RED_DIV)) : r7[5:0];
      rem   = EW'({rr, low_q});
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en[2]) begin
        err_c_q <= neg_q ? -rem : rem;
      end
    end
  end else begin : g_linear
    logic signed [EW-1:0] err_b_q;

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en[1]) begin
        err_b_q <= err_a_q;
      end
      if (ctrl_i.en[2]) begin
        err_c_q <= err_b_q;
      end
    end
  end

  // saturating running sum
  always_comb begin
    sum_ext = (SW+1)'(sum_q) + (SW+1)'(err_c_q);
    if (sum_ext[SW] != sum_ext[SW-1]) begin
      sum_d = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_d = sum_ext[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (ctrl_i.en[3]) begin
      sum_q  <= sum_d;
      prev_q <= err_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      diff_q <= (EW+1)'(err_c_q) - (EW+1)'(prev_q);
    end
  end

  // gain products, integral split in two halves of the sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      pprod_q <= prev_q * $signed(cfg_i.prop_gain);
      dprod_q <= diff_q * $signed(cfg_i.deriv_gain);
      ilo_q   <= $signed({1'b0, sum_q[LW-1:0]}) * $signed(cfg_i.integral_gain);
      ihi_q   <= $signed(sum_q[SW-1:LW]) * $signed(cfg_i.integral_gain);
    end
  end

  always_comb begin
    ihi_ext = ihi_q;
    ilo_ext = ilo_q;
    iprod   = (ihi_ext <<< LW) + ilo_ext;
    ifull   = IS_W'(iprod >>> FRAC_BITS);
    ilim    = IS_W'({1'b0, cfg_i.integral_limit});
    if (ifull > ilim) begin
      iclamp = tpc_pkg::DATA_W'(ilim);
    end else if (ifull < -ilim) begin
      iclamp = tpc_pkg::DATA_W'(-ilim);
    end else begin
      iclamp = tpc_pkg::DATA_W'(ifull);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[5]) begin
      pterm_o <= P_W'(pprod_q >>> FRAC_BITS);
      dterm_o <= D_W'(dprod_q >>> FRAC_BITS);
      iterm_o <= iclamp;
    end
  end

endmodule

// ===== hw/rtl/tpc_merge.sv =====
// merging stage: adds the three terms of each lane, clamps and holds the output word
module tpc_merge #(
  parameter int FRAC_BITS = tpc_pkg::DEF_FRAC_BITS,
  localparam int P_W = tpc_pkg::ERR_W + tpc_pkg::DATA_W - FRAC_BITS,
  localparam int D_W = tpc_pkg::ERR_W + 1 + tpc_pkg::DATA_W - FRAC_BITS
) (
  input  logic                              clk_i,
  input  tpc_pkg::pipe_ctrl_t               ctrl_i,
  input  logic [tpc_pkg::LIMIT_W-1:0]       output_limit_i,
  input  logic signed [P_W-1:0]             pterm_i [tpc_pkg::NUM_LANES],
  input  logic signed [D_W-1:0]             dterm_i [tpc_pkg::NUM_LANES],
  input  logic signed [tpc_pkg::DATA_W-1:0] iterm_i [tpc_pkg::NUM_LANES],
  output logic signed [tpc_pkg::DATA_W-1:0] drive_o [tpc_pkg::NUM_LANES]
);

  localparam int T_W = D_W + 2;

  logic signed [T_W-1:0] total [tpc_pkg::NUM_LANES];
  logic signed [T_W-1:0] lim;
  logic signed [tpc_pkg::DATA_W-1:0] drive_d [tpc_pkg::NUM_LANES];

  always_comb begin
    lim = T_W'({1'b0, output_limit_i});
    for (int l = 0; l < tpc_pkg::NUM_LANES; l++) begin
      total[l] = T_W'(pterm_i[l]) + T_W'(dterm_i[l]) + T_W'(iterm_i[l]);
      if (total[l] > lim) begin
        drive_d[l] = tpc_pkg::DATA_W'(lim);
      end else if (total[l] < -lim) begin
        drive_d[l] = tpc_pkg::DATA_W'(-lim);
      end else begin
        drive_d[l] = tpc_pkg::DATA_W'(total[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[tpc_pkg::NUM_STAGES-1]) begin
      drive_o <= drive_d;
    end
  end

endmodule

// ===== hw/rtl/three_axis_pd_i_position_controller.sv =====
// top level of the three-axis pid position controller
// a word passes every stage listed in tpc_pkg, each with its own valid bit
// throughput: one word per cycle unless out_ready_i stalls; bubbles close up
// the output register lets a new word enter while a result waits to be taken
// reset clears gains, limits, running sums, previous errors and all valid bits
module three_axis_pd_i_position_controller #(
  parameter int AXES      = tpc_pkg::DEF_AXES,
  parameter int FRAC_BITS = tpc_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tpc_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [tpc_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [tpc_pkg::DATA_W-1:0] target_x_i,
  input  logic signed [tpc_pkg::DATA_W-1:0] target_y_i,
  input  logic signed [tpc_pkg::DATA_W-1:0] target_heading_i,
  input  logic signed [tpc_pkg::DATA_W-1:0] measured_x_i,
  input  logic signed [tpc_pkg::DATA_W-1:0] measured_y_i,
  input  logic signed [tpc_pkg::DATA_W-1:0] measured_heading_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tpc_pkg::DATA_W-1:0] drive_x_o,
  output logic signed [tpc_pkg::DATA_W-1:0] drive_y_o,
  output logic signed [tpc_pkg::DATA_W-1:0] drive_heading_o
);

  localparam int P_W = tpc_pkg::ERR_W + tpc_pkg::DATA_W - FRAC_BITS;
  localparam int D_W = tpc_pkg::ERR_W + 1 + tpc_pkg::DATA_W - FRAC_BITS;

  tpc_pkg::cfg_t       cfg_q;
  tpc_pkg::pipe_ctrl_t ctrl;

  logic signed [tpc_pkg::DATA_W-1:0] target   [tpc_pkg::NUM_LANES];
  logic signed [tpc_pkg::DATA_W-1:0] measured [tpc_pkg::NUM_LANES];
  logic signed [P_W-1:0]             pterm    [tpc_pkg::NUM_LANES];
  logic signed [D_W-1:0]             dterm    [tpc_pkg::NUM_LANES];
  logic signed [tpc_pkg::DATA_W-1:0] iterm    [tpc_pkg::NUM_LANES];
  logic signed [tpc_pkg::DATA_W-1:0] drive    [tpc_pkg::NUM_LANES];

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tpc_pkg::REG_PROP_GAIN:      cfg_q.prop_gain      <= cfg_data_i;
        tpc_pkg::REG_INTEGRAL_GAIN:  cfg_q.integral_gain  <= cfg_data_i;
        tpc_pkg::REG_DERIV_GAIN:     cfg_q.deriv_gain     <= cfg_data_i;
        tpc_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data_i[tpc_pkg::LIMIT_W-1:0];
        tpc_pkg::REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_data_i[tpc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  tpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  assign target   = '{target_x_i, target_y_i, target_heading_i};
  assign measured = '{measured_x_i, measured_y_i, measured_heading_i};

  for (genvar g = 0; g < tpc_pkg::NUM_LANES; g++) begin : g_lane
    if (g < AXES) begin : g_on
      tpc_lane #(
        .FRAC_BITS (FRAC_BITS),
        .HEADING   (g == tpc_pkg::HEADING_LANE)
      ) u_lane (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (ctrl),
        .cfg_i      (cfg_q),
        .target_i   (target[g]),
        .measured_i (measured[g]),
        .pterm_o    (pterm[g]),
        .dterm_o    (dterm[g]),
        .iterm_o    (iterm[g])
      );
    end else begin : g_off
      // idle lane drives zero terms, so its output is zero
      assign pterm[g] = '0;
      assign dterm[g] = '0;
      assign iterm[g] = '0;
    end
  end

  tpc_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .output_limit_i (cfg_q.output_limit),
    .pterm_i        (pterm),
    .dterm_i        (dterm),
    .iterm_i        (iterm),
    .drive_o        (drive)
  );

  assign out_valid_o     = ctrl.out_valid;
  assign drive_x_o       = drive[0];
  assign drive_y_o       = drive[1];
  assign drive_heading_o = drive[2];

endmodule
